@@ hw/rtl/mcek_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcek_pkg
// Shared types and constants of the Edmonds-Karp minimum cut block.
// ----------------------------------------------------------------------------
package mcek_pkg;

	localparam int MAX_NODES_DEF   = 16;
	localparam int CAP_BITS_DEF    = 32;
	localparam int NODE_COUNT_W    = 5;
	localparam int NODE_NUM_W      = 5;
	localparam int COST_W          = 24;
	localparam int MAX_RESULTS     = 64;
	localparam int RESULT_CNT_W    = 7;
	localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 5'd16;
	localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_MIN   = 5'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_RD,
		ST_LD_WR1,
		ST_LD_WR2,
		ST_BFS_INIT,
		ST_BFS_POP,
		ST_BFS_SCAN,
		ST_BFS_TAIL,
		ST_AUG_MIN,
		ST_AUG_RD,
		ST_AUG_SUB,
		ST_AUG_ADD,
		ST_CUT_SCAN,
		ST_CUT_FLUSH
	} mcek_state_t;

	typedef struct packed {
		logic                  valid;
		logic [NODE_NUM_W-1:0] src;
		logic [NODE_NUM_W-1:0] snk;
		logic                  last;
	} cut_item_t;

endpackage
`default_nettype wire

@@ hw/rtl/mcek_cap_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcek_cap_mem
// Residual capacity memory: one write and one registered read per cycle,
// per-entry valid bits for an instant clear, write-to-read forwarding.
// ----------------------------------------------------------------------------
module mcek_cap_mem #(
	parameter int AW       = 8,
	parameter int CAP_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                clear,
	input  wire logic                rd_en,
	input  wire logic [AW-1:0]       rd_addr,
	input  wire logic                wr_en,
	input  wire logic [AW-1:0]       wr_addr,
	input  wire logic [CAP_BITS-1:0] wr_data,
	output      logic [CAP_BITS-1:0] rd_data
);
	localparam int DEPTH = 1 << AW;

	logic [CAP_BITS-1:0] mem [DEPTH];
	logic [DEPTH-1:0]    vld_q;
	logic [CAP_BITS-1:0] raw_s1;
	logic [CAP_BITS-1:0] fwd_data_s1;
	logic                fwd_s1;
	logic                hit_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_s1      <= mem[rd_addr];
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			fwd_s1 <= 1'b0;
			hit_s1 <= 1'b0;
		end else begin
			if (rd_en) begin
				fwd_s1 <= wr_en && (wr_addr == rd_addr);
				hit_s1 <= vld_q[rd_addr];
			end
			if (clear) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// a cleared entry reads as zero; a same-cycle write wins over the array
	assign rd_data = fwd_s1 ? fwd_data_s1 : (hit_s1 ? raw_s1 : '0);

endmodule
`default_nettype wire

@@ hw/rtl/mcek_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcek_out_reg
// Result output register on the valid/stall channel.
// ----------------------------------------------------------------------------
module mcek_out_reg (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push_en,
	input  wire mcek_pkg::cut_item_t     push_item,
	output      logic                    out_free,
	output      logic                    out_valid,
	input  wire logic                    out_stall,
	output      mcek_pkg::cut_item_t     item
);
	import mcek_pkg::*;

	logic      vld_q;
	cut_item_t item_q;

	assign out_free  = !vld_q || !out_stall;
	assign out_valid = vld_q;
	assign item      = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (push_en) begin
			vld_q <= 1'b1;
		end else if (!out_stall) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			item_q <= push_item;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/mcek_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcek_ctrl
// Sequencer: edge loading, BFS, path augmentation and cut listing around
// the capacity memory.
// ----------------------------------------------------------------------------
module mcek_ctrl #(
	parameter int MAX_NODES = 16,
	parameter int CAP_BITS  = 32,
	parameter int NW        = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output      logic                              in_stall,
	input  wire logic                              edge_present,
	input  wire logic [mcek_pkg::NODE_NUM_W-1:0]   first_node,
	input  wire logic [mcek_pkg::NODE_NUM_W-1:0]   second_node,
	input  wire logic [mcek_pkg::COST_W-1:0]       edge_cost,
	input  wire logic                              final_edge,
	input  wire logic [mcek_pkg::NODE_COUNT_W-1:0] node_count,
	output      logic                              mem_clear,
	output      logic                              mem_rd_en,
	output      logic [2*NW-1:0]                   mem_rd_addr,
	output      logic                              mem_wr_en,
	output      logic [2*NW-1:0]                   mem_wr_addr,
	output      logic [CAP_BITS-1:0]               mem_wr_data,
	input  wire logic [CAP_BITS-1:0]               mem_rd_data,
	output      logic                              push_en,
	output      mcek_pkg::cut_item_t               push_item,
	input  wire logic                              out_free
);
	import mcek_pkg::*;

	localparam int SW = ((CAP_BITS > COST_W) ? CAP_BITS : COST_W) + 1;
	localparam logic [CAP_BITS-1:0] CAP_MAX = '1;
	localparam logic [NW:0] NODES_LIM = (NW+1)'(MAX_NODES);

	function automatic logic [CAP_BITS-1:0] sat_add(input logic [CAP_BITS-1:0] a,
			input logic [SW-1:0] b);
		logic [SW:0] sum;
		sum = (SW+1)'(a) + (SW+1)'(b);
		if (sum > (SW+1)'(CAP_MAX)) begin
			return CAP_MAX;
		end
		return sum[CAP_BITS-1:0];
	endfunction

	mcek_state_t state_q, state_d;

	logic [MAX_NODES-1:0] nbr_q [MAX_NODES];
	logic [NW-1:0]        parent_q [MAX_NODES];
	logic [NW-1:0]        fifo_q [MAX_NODES];
	logic [MAX_NODES-1:0] seen_q;
	logic [NW-1:0]        a_q, b_q, nlast_q, cur_q, nb_q, s_q, t_q;
	logic [NW:0]          head_q, tail_q, steps_q;
	logic [COST_W-1:0]    cost_q;
	logic [CAP_BITS-1:0]  push_q;
	logic                 final_q, case_open_q, pend_v_q;
	logic [RESULT_CNT_W-1:0] count_q;
	cut_item_t            pend_q;
	logic                 chk_s1, mchk_s1;
	logic [NW-1:0]        nb_s1;

	logic [NODE_COUNT_W-1:0] nn;
	logic                 edge_ok, in_acc, walk_go, bfs_hit, cut_hit, scan_hold;
	logic [NW-1:0]        par_cur;
	cut_item_t            hit_item;

	always_comb begin
		if (node_count < NODE_COUNT_MIN) begin
			nn = NODE_COUNT_MIN;
		end else if (node_count > NODE_COUNT_W'(MAX_NODES)) begin
			nn = NODE_COUNT_W'(MAX_NODES);
		end else begin
			nn = node_count;
		end
	end

	assign edge_ok = edge_present && (first_node != '0) && (first_node <= nn)
			&& (second_node != '0) && (second_node <= nn);
	assign in_acc  = in_valid && (state_q == ST_IDLE);
	assign par_cur = parent_q[cur_q];
	assign walk_go = (cur_q != '0) && (steps_q < NODES_LIM);
	assign bfs_hit = chk_s1 && nbr_q[cur_q][nb_s1] && !seen_q[nb_s1]
			&& (mem_rd_data != '0) && (tail_q < NODES_LIM);
	assign cut_hit = seen_q[s_q] && nbr_q[s_q][t_q] && !seen_q[t_q]
			&& (count_q < RESULT_CNT_W'(MAX_RESULTS));
	assign scan_hold = cut_hit && pend_v_q && !out_free;

	always_comb begin
		hit_item.valid = 1'b1;
		hit_item.src   = NODE_NUM_W'(s_q) + NODE_NUM_W'(1);
		hit_item.snk   = NODE_NUM_W'(t_q) + NODE_NUM_W'(1);
		hit_item.last  = 1'b0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (edge_ok) begin
						state_d = ST_LD_RD;
					end else if (final_edge) begin
						state_d = ST_BFS_INIT;
					end
				end
			end
			ST_LD_RD:    state_d = ST_LD_WR1;
			ST_LD_WR1:   state_d = ST_LD_WR2;
			ST_LD_WR2:   state_d = final_q ? ST_BFS_INIT : ST_IDLE;
			ST_BFS_INIT: state_d = ST_BFS_POP;
			ST_BFS_POP: begin
				if (head_q < tail_q) begin
					state_d = ST_BFS_SCAN;
				end else if (seen_q[1]) begin
					state_d = ST_AUG_MIN;
				end else begin
					state_d = ST_CUT_SCAN;
				end
			end
			ST_BFS_SCAN: state_d = (nb_q == nlast_q) ? ST_BFS_TAIL : ST_BFS_SCAN;
			ST_BFS_TAIL: state_d = ST_BFS_POP;
			ST_AUG_MIN:  state_d = walk_go ? ST_AUG_MIN : ST_AUG_RD;
			ST_AUG_RD:   state_d = walk_go ? ST_AUG_SUB : ST_BFS_INIT;
			ST_AUG_SUB:  state_d = ST_AUG_ADD;
			ST_AUG_ADD:  state_d = ST_AUG_RD;
			ST_CUT_SCAN: begin
				if (!scan_hold && (t_q == nlast_q) && (s_q == nlast_q)) begin
					state_d = ST_CUT_FLUSH;
				end
			end
			ST_CUT_FLUSH: state_d = out_free ? ST_IDLE : ST_CUT_FLUSH;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall    = 1'b1;
		mem_clear   = 1'b0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = '0;
		mem_wr_data = '0;
		push_en     = 1'b0;
		push_item   = pend_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				mem_clear = in_valid && !case_open_q;
			end
			ST_LD_RD: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = {a_q, b_q};
			end
			ST_LD_WR1: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = {a_q, b_q};
				mem_wr_data = sat_add(mem_rd_data, SW'(cost_q));
				mem_rd_en   = 1'b1;
				mem_rd_addr = {b_q, a_q};
			end
			ST_LD_WR2: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = {b_q, a_q};
				mem_wr_data = sat_add(mem_rd_data, SW'(cost_q));
			end
			ST_BFS_SCAN: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = {cur_q, nb_q};
			end
			ST_AUG_MIN, ST_AUG_RD: begin
				mem_rd_en   = walk_go;
				mem_rd_addr = {par_cur, cur_q};
			end
			ST_AUG_SUB: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = {par_cur, cur_q};
				mem_wr_data = mem_rd_data - push_q;
				mem_rd_en   = 1'b1;
				mem_rd_addr = {cur_q, par_cur};
			end
			ST_AUG_ADD: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = {cur_q, par_cur};
				mem_wr_data = sat_add(mem_rd_data, SW'(push_q));
			end
			ST_CUT_SCAN: begin
				push_en = cut_hit && pend_v_q && out_free;
			end
			ST_CUT_FLUSH: begin
				push_en = out_free;
				if (pend_v_q) begin
					push_item.last = 1'b1;
				end else begin
					push_item = '{valid: 1'b0, src: '0, snk: '0, last: 1'b1};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			case_open_q <= 1'b0;
			chk_s1      <= 1'b0;
			mchk_s1     <= 1'b0;
			pend_v_q    <= 1'b0;
			for (int i = 0; i < MAX_NODES; i++) begin
				nbr_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			chk_s1  <= (state_q == ST_BFS_SCAN);
			mchk_s1 <= (state_q == ST_AUG_MIN) && walk_go;
			if (in_acc) begin
				case_open_q <= !final_edge;
				if (!case_open_q) begin
					for (int i = 0; i < MAX_NODES; i++) begin
						nbr_q[i] <= '0;
					end
				end
			end
			// one direction per cycle; a self loop sets the same bit in both states
			if (state_q == ST_LD_RD) begin
				nbr_q[a_q][b_q] <= 1'b1;
			end
			if (state_q == ST_LD_WR1) begin
				nbr_q[b_q][a_q] <= 1'b1;
			end
			if ((state_q == ST_BFS_POP) && (state_d == ST_CUT_SCAN)) begin
				pend_v_q <= 1'b0;
			end else if ((state_q == ST_CUT_SCAN) && cut_hit && !scan_hold) begin
				pend_v_q <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_q     <= NW'(first_node - NODE_NUM_W'(1));
			b_q     <= NW'(second_node - NODE_NUM_W'(1));
			cost_q  <= edge_cost;
			final_q <= final_edge;
			nlast_q <= NW'(nn - NODE_COUNT_W'(1));
		end
		if (bfs_hit) begin
			seen_q[nb_s1]                <= 1'b1;
			parent_q[nb_s1]              <= cur_q;
			fifo_q[tail_q[NW-1:0]]       <= nb_s1;
			tail_q                       <= tail_q + (NW+1)'(1);
		end
		nb_s1 <= nb_q;
		if (mchk_s1 && (mem_rd_data < push_q)) begin
			push_q <= mem_rd_data;
		end
		unique case (state_q)
			ST_BFS_INIT: begin
				seen_q    <= MAX_NODES'(1);
				fifo_q[0] <= '0;
				head_q    <= '0;
				tail_q    <= (NW+1)'(1);
			end
			ST_BFS_POP: begin
				head_q  <= head_q + (NW+1)'(1);
				nb_q    <= '0;
				cur_q   <= (head_q < tail_q) ? fifo_q[head_q[NW-1:0]] : NW'(1);
				steps_q <= '0;
				push_q  <= CAP_MAX;
				s_q     <= '0;
				t_q     <= '0;
				count_q <= '0;
			end
			ST_BFS_SCAN: begin
				nb_q <= nb_q + NW'(1);
			end
			ST_AUG_MIN: begin
				if (walk_go) begin
					cur_q   <= par_cur;
					steps_q <= steps_q + (NW+1)'(1);
				end else begin
					cur_q   <= NW'(1);
					steps_q <= '0;
				end
			end
			ST_AUG_ADD: begin
				cur_q   <= par_cur;
				steps_q <= steps_q + (NW+1)'(1);
			end
			ST_CUT_SCAN: begin
				if (!scan_hold) begin
					if (cut_hit) begin
						pend_q  <= hit_item;
						count_q <= count_q + RESULT_CNT_W'(1);
					end
					if (t_q == nlast_q) begin
						t_q <= '0;
						s_q <= s_q + NW'(1);
					end else begin
						t_q <= t_q + NW'(1);
					end
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/min_cut_edmonds_karp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_cut_edmonds_karp
// Minimum s-t cut of a small undirected graph by Edmonds-Karp max flow.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_stall   | edge_present first_node second_node
//           |                       | edge_cost final_edge
//  result   | out_valid / out_stall | cut_valid cut_source_node cut_sink_node
//           |                       | cut_last
//  config   | cfg_wr_en             | cfg_wr_data (node_count)
//
//  An edge transaction is an accept, then read / write / write of the two
//  capacity words through the single port pair of the memory; an item with no
//  edge is only accepted. The final item starts the solve: each BFS visit pops
//  a node and scans all n nodes, each augmentation walks the path for its
//  minimum, then reads, subtracts and adds along it; the cut listing scans n*n
//  node pairs, plus output stalls. Reset clears control state; the capacity
//  memory is cleared at the first transaction of each case by its valid bits,
//  no sweep. A stalled result holds the listing; input is stalled until done.
// ----------------------------------------------------------------------------
module min_cut_edmonds_karp #(
	parameter int MAX_NODES = mcek_pkg::MAX_NODES_DEF,
	parameter int CAP_BITS  = mcek_pkg::CAP_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output      logic                              in_stall,
	input  wire logic                              edge_present,
	input  wire logic [mcek_pkg::NODE_NUM_W-1:0]   first_node,
	input  wire logic [mcek_pkg::NODE_NUM_W-1:0]   second_node,
	input  wire logic [mcek_pkg::COST_W-1:0]       edge_cost,
	input  wire logic                              final_edge,
	output      logic                              out_valid,
	input  wire logic                              out_stall,
	output      logic                              cut_valid,
	output      logic [mcek_pkg::NODE_NUM_W-1:0]   cut_source_node,
	output      logic [mcek_pkg::NODE_NUM_W-1:0]   cut_sink_node,
	output      logic                              cut_last,
	input  wire logic                              cfg_wr_en,
	input  wire logic [mcek_pkg::NODE_COUNT_W-1:0] cfg_wr_data
);
	import mcek_pkg::*;

	// node index width; capacity address is {row, column}
	localparam int NW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;

	logic [NODE_COUNT_W-1:0] node_count_q;
	logic                    mem_clear, mem_rd_en, mem_wr_en;
	logic [2*NW-1:0]         mem_rd_addr, mem_wr_addr;
	logic [CAP_BITS-1:0]     mem_wr_data, mem_rd_data;
	logic                    push_en, out_free;
	cut_item_t               push_item, item;

	// hold the node count until rewritten
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
		end else if (cfg_wr_en) begin
			node_count_q <= cfg_wr_data;
		end
	end

	mcek_ctrl #(
		.MAX_NODES (MAX_NODES),
		.CAP_BITS  (CAP_BITS),
		.NW        (NW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.edge_present (edge_present),
		.first_node   (first_node),
		.second_node  (second_node),
		.edge_cost    (edge_cost),
		.final_edge   (final_edge),
		.node_count   (node_count_q),
		.mem_clear    (mem_clear),
		.mem_rd_en    (mem_rd_en),
		.mem_rd_addr  (mem_rd_addr),
		.mem_wr_en    (mem_wr_en),
		.mem_wr_addr  (mem_wr_addr),
		.mem_wr_data  (mem_wr_data),
		.mem_rd_data  (mem_rd_data),
		.push_en      (push_en),
		.push_item    (push_item),
		.out_free     (out_free)
	);

	mcek_cap_mem #(
		.AW       (2*NW),
		.CAP_BITS (CAP_BITS)
	) u_cap_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (mem_clear),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_data (mem_rd_data)
	);

	mcek_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (push_en),
		.push_item (push_item),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.item      (item)
	);

	assign cut_valid       = item.valid;
	assign cut_source_node = item.src;
	assign cut_sink_node   = item.snk;
	assign cut_last        = item.last;

endmodule
`default_nettype wire

@@ hw/rtl/mcek_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcek_checker
// Port-level checks on the result channel of the minimum cut block.
// ----------------------------------------------------------------------------
module mcek_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            out_valid,
	input wire logic                            out_stall,
	input wire logic                            cut_valid,
	input wire logic [mcek_pkg::NODE_NUM_W-1:0] cut_source_node,
	input wire logic [mcek_pkg::NODE_NUM_W-1:0] cut_sink_node,
	input wire logic                            cut_last
);
	import mcek_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cut_source_node)
			&& $stable(cut_sink_node) && $stable(cut_last))
		else $error("stalled result changed");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cut_valid |-> cut_last)
		else $error("empty cut not marked last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cut_valid |-> (cut_source_node == '0) && (cut_sink_node == '0))
		else $error("empty cut carries nodes");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cut_valid |-> (cut_source_node != '0) && (cut_sink_node != '0)
			&& (cut_source_node != cut_sink_node))
		else $error("bad cut pair");

endmodule

bind min_cut_edmonds_karp mcek_checker u_mcek_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.cut_valid       (cut_valid),
	.cut_source_node (cut_source_node),
	.cut_sink_node   (cut_sink_node),
	.cut_last        (cut_last)
);
`default_nettype wire
